FILE: design/bqlp_pkg.sv
// shared widths, register indexes and types for the biquad low-pass section
// no dependencies; used by every module of the block
package bqlp_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_WIDTH     = 20;
    localparam int CFG_INDEX_BITS = 8;

    // edge product: coefficient times a sum of two samples
    localparam int PROD_WIDTH  = COEF_WIDTH + SAMPLE_BITS + 1;
    // four products plus rounding stay well inside this
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int SHIFT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_EDGE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_MID  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FB1  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FB2  = CFG_INDEX_BITS'(3);

    localparam logic signed [COEF_WIDTH-1:0] COEF_EDGE_RESET = COEF_WIDTH'(65536);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;

    typedef struct packed {
        coef_t edge_gain;
        coef_t mid_gain;
        coef_t fb1_gain;
        coef_t fb2_gain;
    } coef_set_t;

    typedef struct packed {
        sample_t in_1;
        sample_t in_2;
        sample_t out_1;
        sample_t out_2;
    } hist_t;

    typedef struct packed {
        sample_t sample;
        logic    clipped;
    } result_t;

endpackage

FILE: design/bqlp_coef_regs.sv
// coefficient register file written through the configuration channel
// depends on bqlp_pkg
module bqlp_coef_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [bqlp_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [bqlp_pkg::COEF_WIDTH-1:0]     wr_data,
    output bqlp_pkg::coef_set_t                 coefs
);

    bqlp_pkg::coef_set_t coefs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.edge_gain <= bqlp_pkg::COEF_EDGE_RESET;
            coefs_reg.mid_gain  <= '0;
            coefs_reg.fb1_gain  <= '0;
            coefs_reg.fb2_gain  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                bqlp_pkg::REG_COEF_EDGE: coefs_reg.edge_gain <= wr_data;
                bqlp_pkg::REG_COEF_MID:  coefs_reg.mid_gain  <= wr_data;
                bqlp_pkg::REG_COEF_FB1:  coefs_reg.fb1_gain  <= wr_data;
                bqlp_pkg::REG_COEF_FB2:  coefs_reg.fb2_gain  <= wr_data;
                default:                 ;
            endcase
        end
    end

    assign coefs = coefs_reg;

endmodule

FILE: design/bqlp_datapath.sv
// multiply-accumulate, rounding and saturation for one sample
// depends on bqlp_pkg
module bqlp_datapath
(
    input  bqlp_pkg::sample_t   x0,
    input  bqlp_pkg::hist_t     hist,
    input  bqlp_pkg::coef_set_t coefs,
    output bqlp_pkg::result_t   result
);

    localparam int PW = bqlp_pkg::PROD_WIDTH;
    localparam int AW = bqlp_pkg::ACC_WIDTH;
    localparam int SW = bqlp_pkg::SHIFT_WIDTH;
    localparam int NB = bqlp_pkg::SAMPLE_BITS;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (bqlp_pkg::COEF_FRAC_BITS - 1);

    logic signed [NB:0]    x_sum;
    logic signed [PW-1:0]  prod_edge;
    logic signed [PW-1:0]  prod_mid;
    logic signed [PW-1:0]  prod_fb1;
    logic signed [PW-1:0]  prod_fb2;
    logic signed [AW-1:0]  acc;
    logic signed [SW-1:0]  shifted;
    logic                  pos_over;
    logic                  neg_over;

    assign x_sum     = (NB+1)'(x0) + (NB+1)'(hist.in_2);
    assign prod_edge = PW'(coefs.edge_gain) * PW'(x_sum);
    assign prod_mid  = PW'(coefs.mid_gain)  * PW'(hist.in_1);
    assign prod_fb1  = PW'(coefs.fb1_gain)  * PW'(hist.out_1);
    assign prod_fb2  = PW'(coefs.fb2_gain)  * PW'(hist.out_2);

    assign acc = AW'(prod_edge) + AW'(prod_mid) - AW'(prod_fb1) - AW'(prod_fb2)
               + ROUND_HALF;

    // floor shift
    assign shifted = acc[AW-1:bqlp_pkg::COEF_FRAC_BITS];

    assign pos_over = !shifted[SW-1] && (shifted[SW-2:NB-1] != '0);
    assign neg_over = shifted[SW-1] && (~shifted[SW-2:NB-1] != '0);

    always_comb
    begin
        result.clipped = pos_over || neg_over;
        if (pos_over)
        begin
            result.sample = {1'b0, {(NB-1){1'b1}}};
        end
        else if (neg_over)
        begin
            result.sample = {1'b1, {(NB-1){1'b0}}};
        end
        else
        begin
            result.sample = shifted[NB-1:0];
        end
    end

endmodule

FILE: design/biquad_lowpass_section.sv
// path: input register, combinational multiply-accumulate, output register to the master side
// throughput: one sample per cycle unless the receiver stalls; the feedback path
// closes through the multiply-accumulate between input and result registers
// reset: coefficients return to unity edge gain and zero others, histories clear,
// both stages empty; no clearing pass
// depends on bqlp_pkg, bqlp_coef_regs, bqlp_datapath
module biquad_lowpass_section
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // sample_in

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // sample_out
    output logic [0:0]                          m_tuser,   // clipped

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bqlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bqlp_pkg::COEF_WIDTH-1:0]     cfg_data
);

    bqlp_pkg::coef_set_t coefs;
    bqlp_pkg::hist_t     hist_reg;
    bqlp_pkg::result_t   result;
    bqlp_pkg::result_t   out_reg;
    bqlp_pkg::sample_t   in_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;

    assign cfg_ready = 1'b1;

    bqlp_coef_regs u_coef_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coefs    (coefs)
    );

    bqlp_datapath u_datapath
    (
        .x0     (in_reg),
        .hist   (hist_reg),
        .coefs  (coefs),
        .result (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                hist_reg.in_2  <= hist_reg.in_1;
                hist_reg.in_1  <= in_reg;
                hist_reg.out_2 <= hist_reg.out_1;
                hist_reg.out_1 <= result.sample;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.sample;
    assign m_tuser[0] = out_reg.clipped;

endmodule

FILE: verif/bqlp_checker.sv
// checker for the biquad low-pass section: watches the input, result and coefficient
// channels, predicts each filtered sample and compares it with the block's output
// depends on bqlp_pkg; instantiated beside the block by tb_biquad_lowpass_section
module bqlp_checker
    import bqlp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [15:0]               s_tdata,    // sample_in

    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [15:0]               m_tdata,    // sample_out
    input  logic [0:0]                m_tuser,    // clipped

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]     cfg_data,

    output int                        fail_count,
    output int                        pending,
    output int                        result_count,
    output int                        clip_count
);

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    coef_set_t coefs;
    hist_t     hist;
    result_t   awaited_samples[$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        result_count = 0;
        clip_count   = 0;
    end

    // one filter step: exact accumulate, round half up, saturate, shift histories
    function automatic result_t biquad_step(input sample_t x0);
        longint  acc;
        longint  y;
        result_t r;
        acc = longint'(coefs.edge_gain) * (longint'(x0) + longint'(hist.in_2))
            + longint'(coefs.mid_gain) * longint'(hist.in_1)
            - longint'(coefs.fb1_gain) * longint'(hist.out_1)
            - longint'(coefs.fb2_gain) * longint'(hist.out_2);
        acc = acc + (longint'(1) << (COEF_FRAC_BITS - 1));
        y = acc >>> COEF_FRAC_BITS;
        r.clipped = 1'b0;
        if (y > SAMPLE_MAX)
        begin
            y = SAMPLE_MAX;
            r.clipped = 1'b1;
        end
        else if (y < SAMPLE_MIN)
        begin
            y = SAMPLE_MIN;
            r.clipped = 1'b1;
        end
        r.sample = sample_t'(y);
        hist.in_2  = hist.in_1;
        hist.in_1  = x0;
        hist.out_2 = hist.out_1;
        hist.out_1 = r.sample;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            coefs.edge_gain = COEF_EDGE_RESET;
            coefs.mid_gain  = '0;
            coefs.fb1_gain  = '0;
            coefs.fb2_gain  = '0;
            hist            = '0;
            awaited_samples.delete();
            pending         = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEF_EDGE: coefs.edge_gain = coef_t'(cfg_data);
                    REG_COEF_MID:  coefs.mid_gain  = coef_t'(cfg_data);
                    REG_COEF_FB1:  coefs.fb1_gain  = coef_t'(cfg_data);
                    REG_COEF_FB2:  coefs.fb2_gain  = coef_t'(cfg_data);
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (awaited_samples.size() == 0)
                begin
                    $error("result transaction with nothing awaited: sample_out %0d clipped %0d",
                           $signed(m_tdata), m_tuser[0]);
                    fail_count++;
                end
                else
                begin
                    want = awaited_samples.pop_front();
                    if (want.clipped)
                        clip_count++;
                    if (m_tdata !== want.sample)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want.sample), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.clipped)
                    begin
                        $error("clipped: expected %0d, actual %0d", want.clipped, m_tuser[0]);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                awaited_samples.push_back(biquad_step(sample_t'(s_tdata)));

            pending = awaited_samples.size();
        end
    end

endmodule

FILE: verif/tb_biquad_lowpass_section.sv
// testbench top for biquad_lowpass_section: resets the block, loads coefficient sets,
// streams directed and random samples with bursty input and a stalling receiver
// depends on bqlp_pkg, the block's rtl and bqlp_checker
module tb_biquad_lowpass_section;

    import bqlp_pkg::*;

    localparam int     PHASES        = 10;
    localparam int     PHASE_ITEMS   = 120;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_CYCLES  = 4;
    localparam int     LIMIT_CYCLES  = 200000;

    localparam sample_t SAMPLE_TOP    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam coef_t   COEF_MAX      = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam coef_t   COEF_MIN      = {1'b1, {(COEF_WIDTH-1){1'b0}}};
    localparam coef_t   COEF_UNITY    = COEF_EDGE_RESET;
    localparam coef_t   COEF_HALF     = COEF_WIDTH'(32768);

    localparam int MODE_QUARTER = 0;
    localparam int MODE_TENTH   = 1;
    localparam int MODE_CORNER  = 2;
    localparam int MODE_WILD    = 3;
    localparam int MODE_GENTLE  = 4;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [15:0]               s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [15:0]               m_tdata;
    logic [0:0]                m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COEF_WIDTH-1:0]     cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int clip_count;

    int samples_sent = 0;
    int settings_used = 1;
    int burst_left = 0;
    bit hold_req = 1'b0;

    biquad_lowpass_section dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bqlp_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .clip_count   (clip_count)
    );

    always #4 clk = ~clk;

    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("timeout after %0d cycles, %0d results still awaited", LIMIT_CYCLES, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: segments of its own stall pattern, plus one long hold-off on request
    initial
    begin
        int seg_len;
        int style;
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            seg_len = $urandom_range(1, 40);
            style = $urandom_range(0, 3);
            repeat (seg_len)
            begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // one input transaction; bursts of random length with random gaps between them
    task automatic feed_sample(input sample_t x);
        int gap;
        bit ok;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        samples_sent++;
    endtask

    task automatic write_coef(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [COEF_WIDTH-1:0] value);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
    endtask

    task automatic load_coefs(input coef_t edge_gain, input coef_t mid_gain,
                              input coef_t fb1_gain, input coef_t fb2_gain,
                              input bit stray);
        if (stray)
            write_coef(CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1,
                                                      REG_COEF_FB2 + 1)),
                       COEF_WIDTH'($urandom));
        write_coef(REG_COEF_EDGE, edge_gain);
        write_coef(REG_COEF_MID, mid_gain);
        write_coef(REG_COEF_FB1, fb1_gain);
        write_coef(REG_COEF_FB2, fb2_gain);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // stop offering, wait for every awaited result, then let the pipeline settle
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sample_t unity_run[8];
        sample_t tie_run[6];
        sample_t corner_run[5];
        coef_t   corner[4];
        coef_t   pick[4];
        sample_t x;
        int      mode;

        unity_run  = '{SAMPLE_TOP, 16'sd0, SAMPLE_TOP, SAMPLE_BOTTOM,
                       16'sd0, SAMPLE_BOTTOM, 16'sd0, 16'sd0};
        tie_run    = '{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0};
        corner_run = '{SAMPLE_BOTTOM, SAMPLE_TOP, SAMPLE_BOTTOM, SAMPLE_TOP, 16'sd0};
        corner     = '{COEF_MIN, COEF_MAX, '0, COEF_UNITY};

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: plain sum of current and two-back input, clipping both ways
        foreach (unity_run[i])
            feed_sample(unity_run[i]);
        drain();

        // half gain: exact half-lsb ties in both signs
        load_coefs(COEF_HALF, '0, '0, '0, 1'b0);
        foreach (tie_run[i])
            feed_sample(tie_run[i]);
        drain();

        // all gains at their limits, with a write to an unused index
        load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b1);
        foreach (corner_run[i])
            feed_sample(corner_run[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            mode = (p <= MODE_WILD) ? p : $urandom_range(MODE_QUARTER, MODE_GENTLE);
            case (mode)
                MODE_QUARTER: pick = '{COEF_WIDTH'(19195), COEF_WIDTH'(38390), '0,
                                       COEF_WIDTH'(11244)};
                MODE_TENTH:   pick = '{COEF_WIDTH'(4421), COEF_WIDTH'(8842),
                                       COEF_WIDTH'(-74906), COEF_WIDTH'(27053)};
                MODE_CORNER:
                    foreach (pick[i])
                        pick[i] = corner[2'($urandom_range(0, 3))];
                MODE_WILD:
                    foreach (pick[i])
                        pick[i] = coef_t'($urandom);
                default:
                    foreach (pick[i])
                        pick[i] = coef_t'(int'($urandom_range(0, 131072)) - 65536);
            endcase
            load_coefs(pick[0], pick[1], pick[2], pick[3], ($urandom_range(0, 2) == 0));

            if (p == 2)
                hold_req = 1'b1;

            repeat (PHASE_ITEMS)
            begin
                case ($urandom_range(0, 15))
                    0:       x = SAMPLE_TOP;
                    1:       x = SAMPLE_BOTTOM;
                    2, 3, 4: x = sample_t'(int'($urandom_range(0, 512)) - 256);
                    default: x = sample_t'($urandom);
                endcase
                feed_sample(x);
            end
            drain();
        end

        $display("%0d samples filtered under %0d coefficient settings", samples_sent,
                 settings_used);
        $display("%0d results checked, %0d of them saturated", result_count, clip_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
